[hdl/compartment_chain_transport_step_core_assert.svh]
// ----------------------------------------------------------------------------
// compartment_chain_transport_step_core assertion macros
// Concurrent check wrappers on clk, gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef COMPARTMENT_CHAIN_TRANSPORT_STEP_CORE_ASSERT_SVH
`define COMPARTMENT_CHAIN_TRANSPORT_STEP_CORE_ASSERT_SVH

// property holds at every edge out of reset
`define CCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/cct_pkg.sv]
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types, widths and constants of the compartment chain step core.
// ----------------------------------------------------------------------------
package cct_pkg;

  localparam int ACT_W      = 48;
  localparam int COEF_W     = 32;
  localparam int STEP_W     = 32;
  localparam int HALF_W     = ACT_W / 2;
  localparam int FIELD3_W   = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int IN_W       = 48;
  localparam int OUT_W      = 232;

  localparam int NUM_MARKS     = 5;
  localparam int NUM_MARKS_EFF = (NUM_MARKS > 8) ? 8 : NUM_MARKS;
  localparam int MARK_W        = $clog2(NUM_MARKS_EFF + 1);

  typedef logic [ACT_W-1:0]  act_t;
  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [MARK_W-1:0] mark_t;

  localparam act_t  ACT_MAX = '1;
  localparam coef_t Q_ONE   = 32'h8000_0000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_T01   = 3'd0,
    REG_T12   = 3'd1,
    REG_T23   = 3'd2,
    REG_DECAY = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic  start;
    act_t  a;
    coef_t c;
  } mul_req_t;

  typedef struct packed {
    logic done;
    act_t p;
  } mul_rsp_t;

  // emission thresholds, Q32.16
  function automatic act_t mark_threshold(input mark_t idx);
    act_t thr;
    case (idx)
      MARK_W'(0): thr = 48'd655;
      MARK_W'(1): thr = 48'd6554;
      MARK_W'(2): thr = 48'd32768;
      MARK_W'(3): thr = 48'd58982;
      MARK_W'(4): thr = 48'd64881;
      default:    thr = ACT_MAX;
    endcase
    return thr;
  endfunction

endpackage

[hdl/compartment_chain_transport_step_core.sv]
// ----------------------------------------------------------------------------
// compartment_chain_transport_step_core
// Four-room activity chain with decay and emission threshold tracking.
// ----------------------------------------------------------------------------
// Input stream: in_tdata = source_amount (Q32.16), in_tuser = restart.
// Output stream: one result per input: four room activities, step index,
// crossing flag, crossing index and passed-mark count.
// Config: cfg_we/cfg_addr/cfg_wdata write the three transfer fractions and
// the decay factor (Q1.31, values above 1.0 act as 1.0); write while idle.
// Flow: one step at a time. The first step of a run (after reset or with
// restart set) goes from the transfer through S_FIN to the output register.
// Other steps run ten scalings through one shared 24x32 multiplier, each in
// the steps issue, low half, high half, combine, and then pass through S_FIN;
// the result becomes valid and in_tready returns in the same cycle.
// The result sits in an output register: the next input is taken while it
// waits, and a stalled receiver only holds the finish of the following step.
// Reset: rooms zero, step count zero, marks zero, next step loads the source,
// registers take their default values.
// ----------------------------------------------------------------------------
module compartment_chain_transport_step_core
  import cct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // [47:0] source_amount
  input  logic                  in_tuser,   // [0] restart
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // room0..room3_activity, step_index,
                                            // crossed, crossed_mark, marks_passed
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [COEF_W-1:0]     cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_FIN} state_t;

  typedef enum logic [3:0] {
    OP_R0_KEEP, OP_R0_MOVE, OP_R1_KEEP, OP_R1_MOVE, OP_R2_KEEP, OP_R2_MOVE,
    OP_D0, OP_D1, OP_D2, OP_D3
  } op_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  act_t   src_r, src_nxt;
  act_t   room_r [4];
  act_t   room_nxt [4];
  act_t   n_r [4];
  act_t   n_nxt [4];
  act_t   carry_r, carry_nxt;
  logic   first_r, first_nxt;
  logic   chk_r, chk_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [STEP_W-1:0] this_step_r, this_step_nxt;
  mark_t  mark_r, mark_nxt;

  logic   out_tvalid_r, out_tvalid_nxt;
  act_t   out_room_r [4];
  act_t   out_room_nxt [4];
  logic [STEP_W-1:0]   out_step_r, out_step_nxt;
  logic                out_crossed_r, out_crossed_nxt;
  logic [FIELD3_W-1:0] out_cmark_r, out_cmark_nxt;
  logic [FIELD3_W-1:0] out_marks_r, out_marks_nxt;

  coef_t  t01_r, t12_r, t23_r, decay_r;
  coef_t  t01_c, t12_c, t23_c, decay_c;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  act_t   add_b;
  logic [ACT_W:0] add_sum;
  act_t   sat_sum;
  logic   first_eff;
  logic   cross_hit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t01_r   <= 32'd153391689;
      t12_r   <= 32'd11945248;
      t23_r   <= 32'd11930754;
      decay_r <= Q_ONE;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_T01:   t01_r   <= cfg_wdata;
        REG_T12:   t12_r   <= cfg_wdata;
        REG_T23:   t23_r   <= cfg_wdata;
        REG_DECAY: decay_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign t01_c   = (t01_r   > Q_ONE) ? Q_ONE : t01_r;
  assign t12_c   = (t12_r   > Q_ONE) ? Q_ONE : t12_r;
  assign t23_c   = (t23_r   > Q_ONE) ? Q_ONE : t23_r;
  assign decay_c = (decay_r > Q_ONE) ? Q_ONE : decay_r;

  // operand select for the shared scaler
  always_comb begin
    mreq.start = (state_r == S_ISSUE);
    case (op_r)
      OP_R0_KEEP: begin mreq.a = room_r[0]; mreq.c = Q_ONE - t01_c; end
      OP_R0_MOVE: begin mreq.a = room_r[0]; mreq.c = t01_c;         end
      OP_R1_KEEP: begin mreq.a = room_r[1]; mreq.c = Q_ONE - t12_c; end
      OP_R1_MOVE: begin mreq.a = room_r[1]; mreq.c = t12_c;         end
      OP_R2_KEEP: begin mreq.a = room_r[2]; mreq.c = Q_ONE - t23_c; end
      OP_R2_MOVE: begin mreq.a = room_r[2]; mreq.c = t23_c;         end
      OP_D0:      begin mreq.a = n_r[0];    mreq.c = decay_c;       end
      OP_D1:      begin mreq.a = n_r[1];    mreq.c = decay_c;       end
      OP_D2:      begin mreq.a = n_r[2];    mreq.c = decay_c;       end
      OP_D3:      begin mreq.a = n_r[3];    mreq.c = decay_c;       end
      default:    begin mreq.a = '0;        mreq.c = '0;            end
    endcase
  end

  cct_mulq u_mulq (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  // saturating add of the scaler result
  always_comb begin
    case (op_r)
      OP_R0_KEEP: add_b = src_r;
      OP_R2_MOVE: add_b = room_r[3];
      default:    add_b = carry_r;
    endcase
  end

  assign add_sum = {1'b0, mrsp.p} + {1'b0, add_b};
  assign sat_sum = add_sum[ACT_W] ? ACT_MAX : add_sum[ACT_W-1:0];

  assign first_eff = in_tuser | first_r;
  assign cross_hit = chk_r && (mark_r < MARK_W'(NUM_MARKS_EFF)) &&
                     (room_r[3] > mark_threshold(mark_r));

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    src_nxt        = src_r;
    room_nxt       = room_r;
    n_nxt          = n_r;
    carry_nxt      = carry_r;
    first_nxt      = first_r;
    chk_nxt        = chk_r;
    step_nxt       = step_r;
    this_step_nxt  = this_step_r;
    mark_nxt       = mark_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_room_nxt   = out_room_r;
    out_step_nxt   = out_step_r;
    out_crossed_nxt = out_crossed_r;
    out_cmark_nxt  = out_cmark_r;
    out_marks_nxt  = out_marks_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          src_nxt       = in_tdata[ACT_W-1:0];
          this_step_nxt = in_tuser ? '0 : step_r;
          if (in_tuser) begin
            mark_nxt = '0;
          end
          if (first_eff) begin
            room_nxt[0] = in_tdata[ACT_W-1:0];
            room_nxt[1] = '0;
            room_nxt[2] = '0;
            room_nxt[3] = '0;
            first_nxt   = 1'b0;
            chk_nxt     = 1'b0;
            state_nxt   = S_FIN;
          end else begin
            chk_nxt   = 1'b1;
            op_nxt    = OP_R0_KEEP;
            state_nxt = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (mrsp.done) begin
          case (op_r)
            OP_R0_KEEP: n_nxt[0]    = sat_sum;
            OP_R0_MOVE: carry_nxt   = mrsp.p;
            OP_R1_KEEP: n_nxt[1]    = sat_sum;
            OP_R1_MOVE: carry_nxt   = mrsp.p;
            OP_R2_KEEP: n_nxt[2]    = sat_sum;
            OP_R2_MOVE: n_nxt[3]    = sat_sum;
            OP_D0:      room_nxt[0] = mrsp.p;
            OP_D1:      room_nxt[1] = mrsp.p;
            OP_D2:      room_nxt[2] = mrsp.p;
            OP_D3:      room_nxt[3] = mrsp.p;
            default: ;
          endcase
          if (op_r == OP_D3) begin
            state_nxt = S_FIN;
          end else begin
            op_nxt    = op_t'(op_r + 4'd1);
            state_nxt = S_ISSUE;
          end
        end
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt  = 1'b1;
          out_room_nxt    = room_r;
          out_step_nxt    = this_step_r;
          out_crossed_nxt = cross_hit;
          out_cmark_nxt   = cross_hit ? FIELD3_W'(mark_r) : '0;
          out_marks_nxt   = FIELD3_W'(cross_hit ? mark_r + MARK_W'(1) : mark_r);
          if (cross_hit) begin
            mark_nxt = mark_r + MARK_W'(1);
          end
          step_nxt  = this_step_r + STEP_W'(1);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      op_r         <= OP_R0_KEEP;
      room_r       <= '{default: '0};
      first_r      <= 1'b1;
      chk_r        <= 1'b0;
      step_r       <= '0;
      this_step_r  <= '0;
      mark_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      room_r       <= room_nxt;
      first_r      <= first_nxt;
      chk_r        <= chk_nxt;
      step_r       <= step_nxt;
      this_step_r  <= this_step_nxt;
      mark_r       <= mark_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    src_r         <= src_nxt;
    n_r           <= n_nxt;
    carry_r       <= carry_nxt;
    out_room_r    <= out_room_nxt;
    out_step_r    <= out_step_nxt;
    out_crossed_r <= out_crossed_nxt;
    out_cmark_r   <= out_cmark_nxt;
    out_marks_r   <= out_marks_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_marks_r, out_cmark_r, out_crossed_r, out_step_r,
                       out_room_r[3], out_room_r[2], out_room_r[1], out_room_r[0]};

`include "compartment_chain_transport_step_core_assert.svh"

  `CCT_ASSERT_NEXT(a_busy_after_transfer, in_tvalid && in_tready, !in_tready, "ready after transfer")
  `CCT_ASSERT(a_mark_bound, mark_r <= MARK_W'(NUM_MARKS_EFF), "mark index past table")
  `CCT_ASSERT(a_done_in_wait, mrsp.done |-> state_r == S_WAIT, "scaler done outside wait")
  `CCT_ASSERT(a_cross_count, out_tvalid_r && out_crossed_r |-> out_marks_r == FIELD3_W'(out_cmark_r + 3'd1), "mark count mismatch")

endmodule

[hdl/cct_mulq.sv]
// ----------------------------------------------------------------------------
// cct_mulq
// Shared Q1.31 scaler: p = (a*c + 2^30) >> 31 using one 24x32 multiplier,
// low half first, then high half; result and done are registered together.
// ----------------------------------------------------------------------------
module cct_mulq
  import cct_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int PROD_W = HALF_W + COEF_W;
  localparam int SUM_W  = PROD_W + HALF_W + 1;

  logic [HALF_W-1:0]  op_sel;
  coef_t              c_sel;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W:0]    pl_r;
  logic [PROD_W-1:0]  ph_r;
  logic [HALF_W-1:0]  hi_r;
  coef_t              c_r;
  logic [SUM_W-1:0]   sum;
  act_t               p_r;
  logic               v1_r;
  logic               v2_r;
  logic               done_r;

  // shared multiplier: low half at start, high half next cycle
  assign op_sel = req.start ? req.a[HALF_W-1:0] : hi_r;
  assign c_sel  = req.start ? req.c : c_r;
  assign prod   = op_sel * c_sel;

  assign sum = {1'b0, ph_r, {HALF_W{1'b0}}} + {{(SUM_W-PROD_W-1){1'b0}}, pl_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= req.start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
    if (req.start) begin
      pl_r <= {1'b0, prod} + (PROD_W+1)'(32'h4000_0000);
      hi_r <= req.a[ACT_W-1:HALF_W];
      c_r  <= req.c;
    end
    if (v1_r) begin
      ph_r <= prod;
    end
    if (v2_r) begin
      p_r <= sum[ACT_W+30:31];
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = p_r;

endmodule
